### sv/awc_pkg.sv
// Package for the audio waveshaping clipper: sizes, register and mode codes,
// and the sine, tanh and atan curve tables, built at elaboration.
// Depends on nothing.
package awc_pkg;

    localparam int SAMPLE_BITS       = 24;
    localparam int FRAC_BITS         = SAMPLE_BITS - 4;
    localparam int CURVE_TABLE_DEPTH = 1024;
    localparam int TDATA_W           = ((SAMPLE_BITS + 7) / 8) * 8;

    // configuration port
    localparam int MODE_W     = 3;
    localparam int GAIN_W     = 24;
    localparam int RECIP_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 2'd2;

    localparam logic [MODE_W-1:0] MODE_HARD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CUBIC   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SINE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TANH    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ATAN    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUINTIC = 3'd5;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd4194304;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 32'd65536;

    // shaping datapath, Q22 magnitudes
    localparam int Q_SH  = 22;
    localparam int U_W   = Q_SH + 1;          // holds 1.0
    localparam int ROM_W = 24;
    localparam int K_W   = $clog2(CURVE_TABLE_DEPTH + 1);
    localparam logic [U_W-1:0] Q22_ONE = U_W'(1) << Q_SH;

    // x/3 and x/5 for x < 2^23 as multiply by reciprocal and shift
    localparam int DIV_SH  = 25;
    localparam int DIVM_W  = 24;
    localparam logic [DIVM_W-1:0] DIV3_MUL = 24'd11184811;
    localparam logic [DIVM_W-1:0] DIV5_MUL = 24'd6710887;

    typedef logic [CURVE_TABLE_DEPTH:0][ROM_W-1:0] t_curve_rom;

    // Q28 constants for table generation
    localparam logic [63:0] Q28_ONE        = 64'd1 << 28;
    localparam logic [63:0] PI_Q28         = 64'd843314857;
    localparam logic [63:0] PI_HALF_Q28    = 64'd421657428;
    localparam logic [63:0] PI_QUARTER_Q28 = 64'd210828714;
    localparam logic [63:0] TAN_EIGHTH_Q28 = 64'd111189606;

    // restoring divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] clamp_pos(input longint v);
        return (v < 0) ? 64'd0 : 64'(v);
    endfunction

    // sin(th), th in [0, 3pi/4]
    function automatic logic [63:0] sin_q28(input logic [63:0] th);
        logic [63:0] th2;
        logic [63:0] term;
        longint      sum;
        th2  = (th * th) >> 28;
        term = th;
        sum  = longint'(th);
        for (int n = 1; n <= 13; n++) begin
            term = ((term * th2) >> 28) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        return clamp_pos(sum);
    endfunction

    // exp(-w): series at w/16, then squared four times
    function automatic logic [63:0] exp_neg_q28(input logic [63:0] w);
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] e;
        longint      sum;
        a    = w >> 4;
        term = Q28_ONE;
        sum  = longint'(Q28_ONE);
        for (int n = 1; n <= 16; n++) begin
            term = ((term * a) >> 28) / 64'(n);
            if ((n & 1) != 0) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        e = clamp_pos(sum);
        for (int n = 0; n < 4; n++) begin
            e = (e * e) >> 28;
        end
        return e;
    endfunction

    function automatic logic [63:0] tanh_q28(input logic [63:0] z);
        logic [63:0] e;
        e = exp_neg_q28(2 * z);
        if (e > Q28_ONE) e = Q28_ONE;
        return udiv64((Q28_ONE - e) << 28, Q28_ONE + e);
    endfunction

    function automatic logic [63:0] atan_small_q28(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] pw;
        longint      sum;
        t2  = (t * t) >> 28;
        pw  = t;
        sum = longint'(t);
        for (int k = 1; k <= 20; k++) begin
            pw = (pw * t2) >> 28;
            if ((k & 1) != 0) sum = sum - longint'(pw / 64'(2 * k + 1));
            else sum = sum + longint'(pw / 64'(2 * k + 1));
        end
        return clamp_pos(sum);
    endfunction

    function automatic logic [63:0] atan_q28(input logic [63:0] z_in);
        logic        flip;
        logic [63:0] z;
        logic [63:0] t;
        logic [63:0] a;
        z    = z_in;
        flip = (z > Q28_ONE);
        if (flip) z = udiv64(Q28_ONE << 28, z);
        if (z > TAN_EIGHTH_Q28) begin
            t = udiv64((Q28_ONE - z) << 28, z + Q28_ONE);
            a = PI_QUARTER_Q28 - atan_small_q28(t);
        end else begin
            a = atan_small_q28(z);
        end
        if (flip) a = PI_HALF_Q28 - a;
        return a;
    endfunction

    function automatic logic [31:0] to_q22(input logic [63:0] v);
        return 32'((v + 64'd32) >> 6);
    endfunction

    // table entry k holds the curve at u = k/DEPTH, Q22
    function automatic t_curve_rom build_rom(input logic [MODE_W-1:0] sel);
        t_curve_rom  rom;
        logic [63:0] u;
        logic [63:0] th;
        logic [63:0] v;
        logic [31:0] q;
        rom = '0;
        for (int k = 0; k <= CURVE_TABLE_DEPTH; k++) begin
            u = (64'(k) << 28) / CURVE_TABLE_DEPTH;
            if (sel == MODE_SINE) begin
                th = (u * 64'd3 * PI_Q28) >> 30;
                q  = to_q22(sin_q28(th));
            end else if (sel == MODE_TANH) begin
                v = tanh_q28(64'd5 * u);
                q = to_q22(((v * 64'd3) << 28) / PI_Q28);
            end else begin
                v = atan_q28(64'd5 * u);
                q = to_q22(((v * 64'd2) << 28) / PI_Q28);
            end
            rom[k] = q[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam t_curve_rom SINE_ROM = build_rom(MODE_SINE);
    localparam t_curve_rom TANH_ROM = build_rom(MODE_TANH);
    localparam t_curve_rom ATAN_ROM = build_rom(MODE_ATAN);

endpackage

### sv/audio_waveshaping_clipper.sv
// Audio clipper / waveshaper: eight-stage pipeline, one sample per cycle
// when not stalled. Depends on awc_pkg (sizes, mode codes, curve tables).
//
// Usage:
//   Input samples arrive on the slave stream (i_s_*), tdata[23:0] = sample_in,
//   signed Q3.20. Shaped samples leave on the master stream (o_m_*),
//   tdata[23:0] = sample_out, same format, saturated.
//   curve_mode, threshold_gain and threshold_reciprocal are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no samples are in flight.
// Samples pass stages 0 to 7 in order; o_m_tvalid is the stage 7 valid bit.
// Throughput: one sample per cycle unless stalled; the multipliers are spread
//   over stages 1-6 (scale, square, cube/fourth power, fifth power and table
//   interpolation, reciprocal divide, gain); curve tables are read in stage 3.
// Stall: every stage has a valid bit and loads when it is empty or its
//   successor moves, so bubbles close up and input is still taken while the
//   output register waits; with all eight stages full and i_m_tready low,
//   o_s_tready drops.
// Reset: empties the pipeline and sets curve_mode 0 (hard clip),
//   gain 1.0, reciprocal 1.0. Tables are constant, no fill pass.
module audio_waveshaping_clipper import awc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [TDATA_W-1:0]    i_s_tdata,   // [23:0] sample_in
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TDATA_W-1:0]    o_m_tdata    // [23:0] sample_out
);

    localparam int SB      = SAMPLE_BITS;
    localparam int NSTG    = 8;
    localparam int P1_W    = SB + RECIP_W;
    localparam int SCL_SH  = SB - 10;
    localparam int P_W     = U_W + $clog2(CURVE_TABLE_DEPTH + 1);
    localparam int Y_W     = ROM_W;
    localparam int OUT_SH  = 44 - FRAC_BITS;
    localparam int GSL     = (FRAC_BITS > Q_SH) ? FRAC_BITS - Q_SH : 0;
    localparam int GSR     = (FRAC_BITS > Q_SH) ? 0 : Q_SH - FRAC_BITS;
    localparam int G_W     = GAIN_W + GSL;
    localparam logic [SB-1:0] HALF = SB'(1) << (SB - 1);

    // configuration
    logic [MODE_W-1:0]  r_mode;
    logic [GAIN_W-1:0]  r_gain;
    logic [RECIP_W-1:0] r_recip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HARD;
            r_gain  <= GAIN_RESET;
            r_recip <= RECIP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_RECIP: r_recip <= i_cfg_data[RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stage_en;

    always_comb begin
        stage_en[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            stage_en[s] = !r_vld[s] || stage_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) r_vld[0] <= i_s_tvalid;
            for (int s = 1; s < NSTG; s++) begin
                if (stage_en[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_s_tready = stage_en[0];
    assign o_m_tvalid = r_vld[NSTG-1];

    // stage 0: sign and magnitude
    logic [SB-1:0] n_s0_raw;
    logic          r_s0_neg;
    logic [SB-1:0] r_s0_mag;

    assign n_s0_raw = i_s_tdata[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s0_neg <= n_s0_raw[SB-1];
            r_s0_mag <= n_s0_raw[SB-1] ? (~n_s0_raw + 1'b1) : n_s0_raw;
        end
    end

    // stage 1: scale by the reciprocal, clamp to 1.0
    logic [P1_W-1:0] s1_prod;
    logic [P1_W-1:0] s1_scl;
    logic [U_W-1:0]  n_s1_u;
    logic            r_s1_neg;
    logic [SB-1:0]   r_s1_mag;
    logic [U_W-1:0]  r_s1_u;

    always_comb begin
        s1_prod = P1_W'(r_s0_mag) * P1_W'(r_recip);
        s1_scl  = s1_prod >> SCL_SH;
        n_s1_u  = (s1_scl > P1_W'(Q22_ONE)) ? Q22_ONE : s1_scl[U_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_s1_neg <= r_s0_neg;
            r_s1_mag <= r_s0_mag;
            r_s1_u   <= n_s1_u;
        end
    end

    // stage 2: square, table index and fraction
    logic [2*U_W-1:0] s2_sq;
    logic [P_W-1:0]   s2_p;
    logic             r_s2_neg;
    logic [SB-1:0]    r_s2_mag;
    logic [U_W-1:0]   r_s2_u;
    logic [U_W-1:0]   r_s2_u2;
    logic [K_W-1:0]   r_s2_k;
    logic [Q_SH-1:0]  r_s2_f;

    always_comb begin
        s2_sq = (2*U_W)'(r_s1_u) * (2*U_W)'(r_s1_u);
        s2_p  = P_W'(r_s1_u) * P_W'(CURVE_TABLE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r_s2_neg <= r_s1_neg;
            r_s2_mag <= r_s1_mag;
            r_s2_u   <= r_s1_u;
            r_s2_u2  <= U_W'(s2_sq >> Q_SH);
            r_s2_k   <= K_W'(s2_p >> Q_SH);
            r_s2_f   <= s2_p[Q_SH-1:0];
        end
    end

    // stage 3: cube and fourth power, table reads
    logic [2*U_W-1:0] s3_cu;
    logic [2*U_W-1:0] s3_qu;
    logic [K_W-1:0]   s3_k_hi;
    logic [ROM_W-1:0] n_s3_lo;
    logic [ROM_W-1:0] n_s3_hi;
    logic             r_s3_neg;
    logic [SB-1:0]    r_s3_mag;
    logic [U_W-1:0]   r_s3_u;
    logic [U_W-1:0]   r_s3_u3;
    logic [U_W-1:0]   r_s3_u4;
    logic [ROM_W-1:0] r_s3_lo;
    logic [ROM_W-1:0] r_s3_hi;
    logic [Q_SH-1:0]  r_s3_f;

    always_comb begin
        s3_cu   = (2*U_W)'(r_s2_u2) * (2*U_W)'(r_s2_u);
        s3_qu   = (2*U_W)'(r_s2_u2) * (2*U_W)'(r_s2_u2);
        s3_k_hi = (r_s2_k == K_W'(CURVE_TABLE_DEPTH)) ? r_s2_k : r_s2_k + 1'b1;
        case (r_mode)
            MODE_SINE: begin
                n_s3_lo = SINE_ROM[r_s2_k];
                n_s3_hi = SINE_ROM[s3_k_hi];
            end
            MODE_TANH: begin
                n_s3_lo = TANH_ROM[r_s2_k];
                n_s3_hi = TANH_ROM[s3_k_hi];
            end
            default: begin
                n_s3_lo = ATAN_ROM[r_s2_k];
                n_s3_hi = ATAN_ROM[s3_k_hi];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_s3_neg <= r_s2_neg;
            r_s3_mag <= r_s2_mag;
            r_s3_u   <= r_s2_u;
            r_s3_u3  <= U_W'(s3_cu >> Q_SH);
            r_s3_u4  <= U_W'(s3_qu >> Q_SH);
            r_s3_lo  <= n_s3_lo;
            r_s3_hi  <= n_s3_hi;
            r_s3_f   <= r_s2_f;
        end
    end

    // stage 4: fifth power, u3/3, interpolation step
    logic [2*U_W-1:0]       s4_qi;
    logic [U_W+DIVM_W-1:0]  s4_d3;
    logic                   s4_up;
    logic [ROM_W-1:0]       s4_diff;
    logic [ROM_W+Q_SH-1:0]  s4_step;
    logic                   r_s4_neg;
    logic [SB-1:0]          r_s4_mag;
    logic [U_W-1:0]         r_s4_u;
    logic [U_W-1:0]         r_s4_u5;
    logic [U_W-1:0]         r_s4_q3;
    logic [ROM_W-1:0]       r_s4_lo;
    logic [ROM_W-1:0]       r_s4_dlt;
    logic                   r_s4_up;

    always_comb begin
        s4_qi   = (2*U_W)'(r_s3_u4) * (2*U_W)'(r_s3_u);
        s4_d3   = (U_W+DIVM_W)'(r_s3_u3) * (U_W+DIVM_W)'(DIV3_MUL);
        s4_up   = (r_s3_hi >= r_s3_lo);
        s4_diff = s4_up ? (r_s3_hi - r_s3_lo) : (r_s3_lo - r_s3_hi);
        s4_step = (ROM_W+Q_SH)'(s4_diff) * (ROM_W+Q_SH)'(r_s3_f);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_s4_neg <= r_s3_neg;
            r_s4_mag <= r_s3_mag;
            r_s4_u   <= r_s3_u;
            r_s4_u5  <= U_W'(s4_qi >> Q_SH);
            r_s4_q3  <= U_W'(s4_d3 >> DIV_SH);
            r_s4_lo  <= r_s3_lo;
            r_s4_dlt <= ROM_W'(s4_step >> Q_SH);
            r_s4_up  <= s4_up;
        end
    end

    // stage 5: u5/5 and curve select
    logic [U_W+DIVM_W-1:0] s5_d5;
    logic [U_W-1:0]        s5_q5;
    logic [Y_W-1:0]        n_s5_y;
    logic                  r_s5_neg;
    logic [SB-1:0]         r_s5_mag;
    logic [Y_W-1:0]        r_s5_y;

    always_comb begin
        s5_d5 = (U_W+DIVM_W)'(r_s4_u5) * (U_W+DIVM_W)'(DIV5_MUL);
        s5_q5 = U_W'(s5_d5 >> DIV_SH);
        case (r_mode)
            MODE_CUBIC:   n_s5_y = Y_W'(r_s4_u - r_s4_q3);
            MODE_QUINTIC: n_s5_y = Y_W'(r_s4_u - s5_q5);
            default:      n_s5_y = r_s4_up ? (r_s4_lo + r_s4_dlt) : (r_s4_lo - r_s4_dlt);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_s5_neg <= r_s4_neg;
            r_s5_mag <= r_s4_mag;
            r_s5_y   <= n_s5_y;
        end
    end

    // stage 6: gain multiply, hard clip, passthrough
    logic [Y_W+GAIN_W-1:0] s6_prod;
    logic [G_W-1:0]        s6_g;
    logic [SB-1:0]         n_s6_res;
    logic                  r_s6_neg;
    logic [SB-1:0]         r_s6_res;

    always_comb begin
        s6_prod = (Y_W+GAIN_W)'(r_s5_y) * (Y_W+GAIN_W)'(r_gain);
        s6_g    = (G_W'(r_gain) << GSL) >> GSR;
        if (r_mode == MODE_HARD) begin
            n_s6_res = (r_s5_mag < s6_g) ? r_s5_mag : SB'(s6_g);
        end else if (r_mode inside {[MODE_CUBIC:MODE_QUINTIC]}) begin
            n_s6_res = SB'(s6_prod >> OUT_SH);
        end else begin
            n_s6_res = r_s5_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            r_s6_neg <= r_s5_neg;
            r_s6_res <= n_s6_res;
        end
    end

    // stage 7: saturate and restore sign, output register
    logic [SB-1:0] s7_sat;
    logic [SB-1:0] r_s7_data;

    always_comb begin
        if (r_s6_neg) s7_sat = (r_s6_res > HALF) ? HALF : r_s6_res;
        else s7_sat = (r_s6_res > HALF - 1'b1) ? HALF - 1'b1 : r_s6_res;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[7]) begin
            r_s7_data <= r_s6_neg ? (~s7_sat + 1'b1) : s7_sat;
        end
    end

    assign o_m_tdata = TDATA_W'(r_s7_data);

    // checks
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_full_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while pipeline full and stalled");

    a_accept_enters_stage0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted sample not in first stage");

    a_stall_keeps_output_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !i_m_tready) |=> (r_vld[NSTG-1] && $stable(r_s7_data)))
        else $error("stalled result lost or changed");

endmodule

### dv/audio_waveshaping_clipper_tb.sv
// Testbench for audio_waveshaping_clipper: directed and random samples over all curve modes,
// checked against a bit-exact fixed-point clipper/waveshaper model kept in this file.
// Depends on awc_pkg for port widths, register indexes and mode codes.
module audio_waveshaping_clipper_tb import awc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAB_N          = 1024;
    localparam int SCALE_SH       = SAMPLE_BITS - 10;
    localparam int OUT_SH         = 44 - FRAC_BITS;
    localparam int GAIN_SH        = 22 - FRAC_BITS;
    localparam int IDLE_PCT       = 20;
    localparam int PIPE_DEPTH     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 25;
    localparam int PHASE_ITEMS    = 50;
    localparam int STEADY_PHASE   = 12;

    localparam logic [MODE_W-1:0]  MODE_THRU6 = 3'd6;
    localparam logic [MODE_W-1:0]  MODE_THRU7 = 3'd7;
    localparam logic [GAIN_W-1:0]  GAIN_MAX   = '1;
    localparam logic [RECIP_W-1:0] RECIP_MAX  = '1;

    localparam logic [63:0] ONE28      = 64'd1 << 28;
    localparam logic [63:0] ONE22      = 64'd1 << 22;
    localparam logic [63:0] PI28       = 64'd843314857;
    localparam logic [63:0] HALF_PI28  = 64'd421657428;
    localparam logic [63:0] QTR_PI28   = 64'd210828714;
    localparam logic [63:0] TAN_PI8_28 = 64'd111189606;
    localparam logic [63:0] HALF_SCALE = 64'd1 << (SAMPLE_BITS - 1);
    localparam logic [63:0] FULL_SCALE = 64'd1 << SAMPLE_BITS;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [GAIN_W-1:0]  gain;
        logic [RECIP_W-1:0] recip;
        int                 sample;
        bit                 typed;
        int                 result;
    } t_clip_case;

    typedef struct packed {
        bit                     typed;
        logic [SAMPLE_BITS-1:0] value;
    } t_pending;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [TDATA_W-1:0]    i_s_tdata;   // [23:0] sample_in
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [TDATA_W-1:0]    o_m_tdata;   // [23:0] sample_out

    // curve tables, Q22, entry k at u = k/TAB_N
    logic [31:0] sine_tab [0:TAB_N];
    logic [31:0] tanh_tab [0:TAB_N];
    logic [31:0] atan_tab [0:TAB_N];

    // register copies, tracked from the write port
    logic [MODE_W-1:0]  mdl_mode  = MODE_HARD;
    logic [GAIN_W-1:0]  mdl_gain  = GAIN_RESET;
    logic [RECIP_W-1:0] mdl_recip = RECIP_RESET;

    t_pending               typed_q  [$];
    logic [SAMPLE_BITS-1:0] shaped_q [$];
    int                     fail_count   = 0;
    int                     stall_cycles = 0;
    bit                     steady       = 0;

    t_clip_case clip_cases [23] = '{
        '{MODE_HARD,    GAIN_RESET, RECIP_RESET, 0,        1, 0},
        '{MODE_HARD,    GAIN_RESET, RECIP_RESET, 8388607,  1, 1048576},
        '{MODE_HARD,    GAIN_RESET, RECIP_RESET, -8388608, 1, -1048576},
        '{MODE_HARD,    GAIN_RESET, RECIP_RESET, 1000,     1, 1000},
        '{MODE_HARD,    GAIN_MAX,   RECIP_RESET, 8388607,  1, 4194303},
        '{MODE_HARD,    GAIN_MAX,   RECIP_RESET, -8388608, 1, -4194303},
        '{MODE_HARD,    GAIN_MAX,   RECIP_MAX,   5592405,  1, 4194303},
        '{MODE_HARD,    24'd0,      RECIP_RESET, -5,       1, 0},
        '{MODE_CUBIC,   GAIN_RESET, RECIP_RESET, 1048576,  0, 0},
        '{MODE_CUBIC,   GAIN_RESET, RECIP_RESET, -524288,  0, 0},
        '{MODE_CUBIC,   GAIN_RESET, 32'd0,       8388607,  1, 0},
        '{MODE_SINE,    GAIN_RESET, RECIP_RESET, 1048576,  0, 0},
        '{MODE_SINE,    GAIN_RESET, RECIP_RESET, -300000,  0, 0},
        '{MODE_SINE,    GAIN_MAX,   RECIP_MAX,   1,        0, 0},
        '{MODE_TANH,    GAIN_RESET, RECIP_RESET, 8388607,  0, 0},
        '{MODE_TANH,    24'd0,      RECIP_RESET, 8388607,  1, 0},
        '{MODE_ATAN,    GAIN_RESET, RECIP_RESET, -8388608, 0, 0},
        '{MODE_ATAN,    GAIN_RESET, RECIP_RESET, 123457,   0, 0},
        '{MODE_QUINTIC, GAIN_RESET, RECIP_RESET, 1048576,  0, 0},
        '{MODE_QUINTIC, GAIN_MAX,   RECIP_MAX,   -8388608, 0, 0},
        '{MODE_THRU6,   GAIN_RESET, RECIP_RESET, -8388608, 1, -8388608},
        '{MODE_THRU7,   GAIN_RESET, RECIP_RESET, 8388607,  1, 8388607},
        '{MODE_THRU7,   GAIN_RESET, RECIP_RESET, -1,       1, -1}
    };

    audio_waveshaping_clipper u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---- table generation, Q28 series ----

    // sin(th) for th in [0, 3pi/4]
    function automatic logic [63:0] series_sin(input logic [63:0] th);
        logic [63:0] th2;
        logic [63:0] term;
        longint      acc;
        th2  = (th * th) >> 28;
        term = th;
        acc  = longint'(th);
        for (int n = 1; n <= 13; n++) begin
            term = ((term * th2) >> 28) / 64'((2 * n) * (2 * n + 1));
            acc  = (n % 2 != 0) ? acc - longint'(term) : acc + longint'(term);
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    // exp(-w): series at w/16, squared four times
    function automatic logic [63:0] decay_exp(input logic [63:0] w);
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] e;
        longint      acc;
        a    = w >> 4;
        term = ONE28;
        acc  = longint'(ONE28);
        for (int n = 1; n <= 16; n++) begin
            term = ((term * a) >> 28) / 64'(n);
            acc  = (n % 2 != 0) ? acc - longint'(term) : acc + longint'(term);
        end
        e = (acc < 0) ? 64'd0 : 64'(acc);
        for (int n = 0; n < 4; n++) e = (e * e) >> 28;
        return e;
    endfunction

    function automatic logic [63:0] tanh_fx(input logic [63:0] z);
        logic [63:0] e;
        e = decay_exp(2 * z);
        if (e > ONE28) e = ONE28;
        return ((ONE28 - e) << 28) / (ONE28 + e);
    endfunction

    // atan(t) for t up to tan(pi/8)
    function automatic logic [63:0] atan_core(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] pw;
        longint      acc;
        t2  = (t * t) >> 28;
        pw  = t;
        acc = longint'(t);
        for (int k = 1; k <= 20; k++) begin
            pw  = (pw * t2) >> 28;
            acc = (k % 2 != 0) ? acc - longint'(pw / 64'(2 * k + 1))
                               : acc + longint'(pw / 64'(2 * k + 1));
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    // range reduction: 1/z above one, then pi/4 fold above tan(pi/8)
    function automatic logic [63:0] atan_fx(input logic [63:0] z_in);
        logic        flip;
        logic [63:0] z;
        logic [63:0] ang;
        z    = z_in;
        flip = (z > ONE28);
        if (flip) z = (ONE28 << 28) / z;
        if (z > TAN_PI8_28) ang = QTR_PI28 - atan_core(((ONE28 - z) << 28) / (z + ONE28));
        else ang = atan_core(z);
        if (flip) ang = HALF_PI28 - ang;
        return ang;
    endfunction

    function automatic logic [31:0] round_q22(input logic [63:0] v);
        return 32'((v + 64'd32) >> 6);
    endfunction

    // ---- sample datapath ----

    function automatic logic [63:0] table_interp(input logic [MODE_W-1:0] mode,
                                                 input logic [63:0] u);
        logic [63:0] p;
        logic [63:0] f;
        logic [63:0] lo;
        logic [63:0] hi;
        int          k;
        p = u * TAB_N;
        k = int'(p >> 22);
        f = p & (ONE22 - 1);
        // top entry: interpolate the last segment fully, which lands on it exactly
        if (k >= TAB_N) begin
            k = TAB_N - 1;
            f = ONE22;
        end
        case (mode)
            MODE_SINE: begin
                lo = sine_tab[k];
                hi = sine_tab[k + 1];
            end
            MODE_TANH: begin
                lo = tanh_tab[k];
                hi = tanh_tab[k + 1];
            end
            default: begin
                lo = atan_tab[k];
                hi = atan_tab[k + 1];
            end
        endcase
        if (hi >= lo) return lo + (((hi - lo) * f) >> 22);
        return lo - (((lo - hi) * f) >> 22);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] shape_sample(input logic [SAMPLE_BITS-1:0] x);
        logic [63:0] mag;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u5;
        logic [63:0] y;
        logic [63:0] res;
        logic [63:0] lim;
        mag = x[SAMPLE_BITS-1] ? FULL_SCALE - 64'(x) : 64'(x);
        if (mdl_mode == MODE_HARD) begin
            lim = 64'(mdl_gain) >> GAIN_SH;
            res = (mag < lim) ? mag : lim;
        end else if (mdl_mode <= MODE_QUINTIC) begin
            u = (mag * 64'(mdl_recip)) >> SCALE_SH;
            if (u > ONE22) u = ONE22;
            u2 = (u * u) >> 22;
            u3 = (u2 * u) >> 22;
            u5 = (((u2 * u2) >> 22) * u) >> 22;
            case (mdl_mode)
                MODE_CUBIC: y = u - u3 / 3;
                MODE_QUINTIC: y = u - u5 / 5;
                default: y = table_interp(mdl_mode, u);
            endcase
            res = (y * 64'(mdl_gain)) >> OUT_SH;
        end else begin
            res = mag;
        end
        if (x[SAMPLE_BITS-1]) begin
            if (res > HALF_SCALE) res = HALF_SCALE;
            return SAMPLE_BITS'(FULL_SCALE - res);
        end
        if (res > HALF_SCALE - 1) res = HALF_SCALE - 1;
        return SAMPLE_BITS'(res);
    endfunction

    // ---- scoreboard: register tracking, input/output transactions, watchdog ----
    always @(posedge i_clk) begin
        t_pending               entry;
        logic [SAMPLE_BITS-1:0] want;
        logic [SAMPLE_BITS-1:0] got;
        bit                     moved;
        moved = 0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:  mdl_mode  = i_cfg_data[MODE_W-1:0];
                    CFG_GAIN:  mdl_gain  = i_cfg_data[GAIN_W-1:0];
                    CFG_RECIP: mdl_recip = i_cfg_data[RECIP_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                moved = 1;
                if (typed_q.size() == 0) begin
                    $error("input transaction with no stimulus entry queued");
                    fail_count++;
                end else begin
                    entry = typed_q.pop_front();
                    shaped_q.push_back(entry.typed ? entry.value
                                                   : shape_sample(i_s_tdata[SAMPLE_BITS-1:0]));
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                moved = 1;
                got   = o_m_tdata[SAMPLE_BITS-1:0];
                if (shaped_q.size() == 0) begin
                    $error("unexpected output transaction, sample_out %0d", $signed(got));
                    fail_count++;
                end else begin
                    want = shaped_q.pop_front();
                    if (got !== want) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(got));
                        fail_count++;
                    end
                end
            end
        end
        stall_cycles = (moved || !i_rst_n) ? 0 : stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side back-pressure
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---- stimulus ----

    // called right after a rising edge (or at start); returns at the accepting edge
    task automatic push_sample(input logic [SAMPLE_BITS-1:0] s, input bit typed,
                               input logic [SAMPLE_BITS-1:0] value);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        typed_q.push_back('{typed, value});
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDATA_W'(s);
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain_pipe();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (shaped_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH) @(negedge i_clk);
    endtask

    // writes mode, gain and reciprocal in turn; pipeline must be empty
    task automatic program_regs(input logic [MODE_W-1:0] mode, input logic [GAIN_W-1:0] gain,
                                input logic [RECIP_W-1:0] recip);
        drain_pipe();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MODE;
        i_cfg_data <= CFG_DATA_W'(mode);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_GAIN;
        i_cfg_data <= CFG_DATA_W'(gain);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_RECIP;
        i_cfg_data <= CFG_DATA_W'(recip);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [GAIN_W-1:0] gain);
        logic [31:0] lim;
        logic [31:0] mag;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            1: mag = $urandom_range(2047);
            2, 3: begin
                // around the clip threshold, in sample format
                lim = 32'(gain >> GAIN_SH) * 2;
                if (lim > 32'(HALF_SCALE - 1)) lim = 32'(HALF_SCALE - 1);
                mag = $urandom_range(lim);
            end
            default: return SAMPLE_BITS'($urandom());
        endcase
        return $urandom_range(1) ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
    endfunction

    initial begin
        logic [MODE_W-1:0]  cur_mode;
        logic [GAIN_W-1:0]  cur_gain;
        logic [RECIP_W-1:0] cur_recip;
        logic [63:0]        u;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_MODE;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;

        for (int k = 0; k <= TAB_N; k++) begin
            u = (64'(k) << 28) / TAB_N;
            sine_tab[k] = round_q22(series_sin((u * 3 * PI28) >> 30));
            tanh_tab[k] = round_q22(((tanh_fx(5 * u) * 3) << 28) / PI28);
            atan_tab[k] = round_q22(((atan_fx(5 * u) * 2) << 28) / PI28);
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_mode  = MODE_HARD;
        cur_gain  = GAIN_RESET;
        cur_recip = RECIP_RESET;
        foreach (clip_cases[i]) begin
            if (clip_cases[i].mode != cur_mode || clip_cases[i].gain != cur_gain ||
                clip_cases[i].recip != cur_recip) begin
                cur_mode  = clip_cases[i].mode;
                cur_gain  = clip_cases[i].gain;
                cur_recip = clip_cases[i].recip;
                program_regs(cur_mode, cur_gain, cur_recip);
            end
            push_sample(SAMPLE_BITS'(clip_cases[i].sample), clip_cases[i].typed,
                        SAMPLE_BITS'(clip_cases[i].result));
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            cur_mode = ($urandom_range(9) == 0) ? MODE_W'(6 + $urandom_range(1))
                                                : MODE_W'($urandom_range(5));
            case ($urandom_range(9))
                0: cur_gain = '0;
                1: cur_gain = GAIN_MAX;
                2, 3: cur_gain = GAIN_W'($urandom());
                default: cur_gain = GAIN_W'($urandom_range(32'd4194304, 32'd65536));
            endcase
            case ($urandom_range(7))
                0: cur_recip = '0;
                1: cur_recip = RECIP_MAX;
                2: cur_recip = $urandom();
                default: begin
                    // matched reciprocal: 1/gain from Q2.22 to Q16.16
                    if (cur_gain == 0) u = 64'(RECIP_MAX);
                    else u = (64'd1 << 38) / 64'(cur_gain);
                    cur_recip = (u > 64'(RECIP_MAX)) ? RECIP_MAX : RECIP_W'(u);
                end
            endcase
            program_regs(cur_mode, cur_gain, cur_recip);
            steady = (ph == STEADY_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_sample(pick_sample(cur_gain), 1'b0, '0);
            end
            steady = 0;
        end

        drain_pipe();
        repeat (PIPE_DEPTH) @(posedge i_clk);
        if (fail_count == 0 && shaped_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
